/* rtl/core/rk4_pkg.sv */
// Package for the RK4 cubic ODE stepper: payload structs, fixed-point widths,
// command and register codes, and the shared saturation helpers. No dependencies.
`timescale 1ns / 1ps

package rk4_pkg;

   localparam int RK4_DATA_WIDTH = 32;
   localparam int FIX_W          = 32;   // Q16.16 value width
   localparam int STEP_W         = 31;   // unsigned step size width
   localparam int FRAC_BITS      = 16;
   localparam int PROD_W         = 2 * FIX_W;
   localparam int WIDE_W         = 48;   // headroom for sums and shifted products
   localparam int ACC_W          = 35;   // k1 + 2k2 + 2k3 + k4
   localparam int DIV_W          = 36;   // biased dividend for the divide by six
   localparam int DIV_DIGIT_W    = 4;
   localparam int DIV_DIGITS     = DIV_W / DIV_DIGIT_W;
   localparam int DIV_CNT_W      = $clog2(DIV_DIGITS);
   localparam int CSR_IDX_W      = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_H = 2'd2;

   localparam logic [STEP_W-1:0] STEP_RESET = 31'd6554;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   // floor(t/6) = floor((t + 6*2^32)/6) - 2^32 keeps the dividend positive
   localparam logic signed [DIV_W:0]    DIV_OFFSET = 37'sh6_0000_0000;
   localparam logic signed [WIDE_W-1:0] QUOT_BIAS  = 48'sh1_0000_0000;
   localparam logic signed [ACC_W-1:0]  DIV_ROUND  = 35'sd3;

   typedef struct packed {
      logic                    command;
      logic signed [FIX_W-1:0] start_value;
   } req_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] state_value;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic                    clip;
      logic signed [FIX_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Upper saturation bound; the usable width is clamped to 16..32 bits.
   function automatic logic signed [WIDE_W-1:0] sat_bound(input int w);
      int e;
      e = w;
      if (e > FIX_W) e = FIX_W;
      if (e < 16) e = 16;
      return (48'sd1 <<< (e - 1)) - 48'sd1;
   endfunction

   function automatic sat_type sat_fx(input logic signed [WIDE_W-1:0] v,
                                      input logic signed [WIDE_W-1:0] hi);
      sat_type                  r;
      logic signed [WIDE_W-1:0] lo;
      lo = -hi - 48'sd1;
      if (v > hi) begin
         r.clip  = 1'b1;
         r.value = hi[FIX_W-1:0];
      end else if (v < lo) begin
         r.clip  = 1'b1;
         r.value = lo[FIX_W-1:0];
      end else begin
         r.clip  = 1'b0;
         r.value = v[FIX_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/rk4_fxmul.sv */
// Shared Q16.16 multiplier: registered 32x32 product, then round to nearest
// and saturate. Depends on rk4_pkg.
`timescale 1ns / 1ps

module rk4_fxmul
   import rk4_pkg::*;
#(
   parameter int DATA_WIDTH = RK4_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic signed [FIX_W-1:0] mul_a,
   input  logic signed [FIX_W-1:0] mul_b,
   output sat_type                 mul_res
);

   localparam logic signed [WIDE_W-1:0] SAT_HI = sat_bound(DATA_WIDTH);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [WIDE_W-1:0] shifted;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // result is valid in the cycle after the operands are presented
   always_comb begin
      rnd     = prod_ff + ROUND_HALF;
      shifted = rnd[PROD_W-1:FRAC_BITS];
      mul_res = sat_fx(shifted, SAT_HI);
   end

endmodule

/* rtl/core/rk4_div6.sv */
// Radix-16 digit-serial divide by six of an unsigned dividend, one quotient
// digit per cycle. Depends on rk4_pkg.
`timescale 1ns / 1ps

module rk4_div6
   import rk4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [DIV_W-1:0] dividend,
   output div_rsp_type      div_rsp
);

   logic [DIV_W-1:0]     shreg_ff, shreg_in;
   logic [2:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           part;
   logic [DIV_DIGIT_W-1:0] digit;
   logic [6:0]           rem_full;

   // floor(v/6) for v < 96 as (v*43) >> 8
   function automatic logic [DIV_DIGIT_W-1:0] digit6(input logic [6:0] v);
      logic [12:0] p;
      p = {6'd0, v} * 13'd43;
      return p[11:8];
   endfunction

   always_comb begin
      part     = {rem_ff, shreg_ff[DIV_W-1 -: DIV_DIGIT_W]};
      digit    = digit6(part);
      rem_full = part - ({3'd0, digit} * 7'd6);
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_start) begin
         shreg_in = dividend;
         rem_in   = 3'd0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[DIV_W-DIV_DIGIT_W-1:0], digit};
         rem_in   = rem_full[2:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = shreg_ff;

endmodule

/* rtl/core/rk4_cubic_ode_step_top.sv */
// Top level of the RK4 stepper for dx/dt = -x^3 + a*x - b in Q16.16:
// sequencer, state and config registers. Depends on rk4_pkg, rk4_fxmul, rk4_div6.
//
//   channel  ports                                 direction  moves
//   req      req_valid req_ready req_item          in         command, start value
//   rsp      rsp_valid rsp_ready rsp_item          out        new x, saturation flag
//   csr      csr_valid csr_ready csr_index csr_data in        coef a, coef b, step h
//
// A load item is taken in the idle state; a step item runs four slope evaluations
// on the shared multiplier, then the divide by six, then the increment and update.
// Reset (synchronous) clears x and restores the register defaults.
// req_ready is high only when the sequencer is idle and the result register is
// free or being emptied; a stalled result holds the sequencer at its last state.
`timescale 1ns / 1ps

module rk4_cubic_ode_step_top
   import rk4_pkg::*;
#(
   parameter int DATA_WIDTH = RK4_DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIX_W-1:0]     csr_data
);

   localparam logic signed [WIDE_W-1:0] SAT_HI = sat_bound(DATA_WIDTH);
   localparam logic [1:0] STAGE_K2   = 2'd1;
   localparam logic [1:0] STAGE_K3   = 2'd2;
   localparam logic [1:0] STAGE_LAST = 2'd3;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_SQ_ISS   = 12'b0000_0000_0010,
      S_SQ_WB    = 12'b0000_0000_0100,
      S_LIN_WB   = 12'b0000_0000_1000,
      S_CUBE_WB  = 12'b0000_0001_0000,
      S_F_CALC   = 12'b0000_0010_0000,
      S_K_ISS    = 12'b0000_0100_0000,
      S_K_WB     = 12'b0000_1000_0000,
      S_DIV_ISS  = 12'b0001_0000_0000,
      S_DIV_WAIT = 12'b0010_0000_0000,
      S_INC      = 12'b0100_0000_0000,
      S_UPD      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [FIX_W-1:0] x_ff, x_in;
   logic signed [FIX_W-1:0] t_ff, t_in;
   logic signed [FIX_W-1:0] sq_ff, sq_in;
   logic signed [FIX_W-1:0] lin_ff, lin_in;
   logic signed [FIX_W-1:0] cube_ff, cube_in;
   logic signed [FIX_W-1:0] f_ff, f_in;
   logic signed [FIX_W-1:0] inc_ff, inc_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [1:0]              stage_ff, stage_in;
   logic                    clip_ff, clip_in;
   logic signed [FIX_W-1:0] coef_a_ff, coef_a_in;
   logic signed [FIX_W-1:0] coef_b_ff, coef_b_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_item_ff, rsp_item_in;

   logic signed [FIX_W-1:0] mul_a, mul_b;
   sat_type                 mul_res;
   logic                    div_start;
   logic [DIV_W-1:0]        dividend;
   div_rsp_type             div_rsp;

   logic                    out_free;
   sat_type                 ld_sat, f_sat, trial_sat, inc_sat, upd_sat;
   logic signed [FIX_W-1:0] k_half;
   logic signed [ACC_W-1:0] k_term;
   logic signed [DIV_W:0]   biased;
   logic signed [WIDE_W-1:0] quot_s;

   rk4_fxmul #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .mul_res(mul_res)
   );

   rk4_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .div_start(div_start),
      .dividend (dividend),
      .div_rsp  (div_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // datapath terms shared by several states
   always_comb begin
      ld_sat = sat_fx(WIDE_W'(req_item.start_value), SAT_HI);
      f_sat  = sat_fx(WIDE_W'(lin_ff) - WIDE_W'(cube_ff) - WIDE_W'(coef_b_ff), SAT_HI);
      k_half = (stage_ff == STAGE_K3) ? mul_res.value : (mul_res.value >>> 1);
      trial_sat = sat_fx(WIDE_W'(x_ff) + WIDE_W'(k_half), SAT_HI);
      // k2 and k3 count twice
      if (stage_ff == STAGE_K2 || stage_ff == STAGE_K3) begin
         k_term = ACC_W'(mul_res.value) <<< 1;
      end else begin
         k_term = ACC_W'(mul_res.value);
      end
      biased   = (DIV_W + 1)'(acc_ff + DIV_ROUND) + DIV_OFFSET;
      dividend = biased[DIV_W-1:0];
      quot_s   = signed'(WIDE_W'(div_rsp.quotient)) - QUOT_BIAS;
      inc_sat  = sat_fx(quot_s, SAT_HI);
      upd_sat  = sat_fx(WIDE_W'(x_ff) + WIDE_W'(inc_ff), SAT_HI);
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = t_ff;
      mul_b = t_ff;
      unique case (state_ff)
         S_SQ_WB: begin
            mul_a = coef_a_ff;
         end
         S_LIN_WB: begin
            mul_a = sq_ff;
         end
         S_K_ISS: begin
            mul_a = signed'({1'b0, step_ff});
            mul_b = f_ff;
         end
         default: begin
            mul_a = t_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      sq_in        = sq_ff;
      lin_in       = lin_ff;
      cube_in      = cube_ff;
      f_in         = f_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      stage_in     = stage_ff;
      clip_in      = clip_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;

      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      step_in   = step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_A: coef_a_in = signed'(csr_data);
            CSR_COEF_B: coef_b_in = signed'(csr_data);
            CSR_STEP_H: step_in   = csr_data[STEP_W-1:0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_item.command == CMD_STEP) begin
                  t_in     = x_ff;
                  acc_in   = '0;
                  stage_in = '0;
                  clip_in  = 1'b0;
                  state_in = S_SQ_ISS;
               end else begin
                  x_in                    = ld_sat.value;
                  rsp_item_in.state_value = ld_sat.value;
                  rsp_item_in.saturated   = ld_sat.clip;
                  rsp_valid_in            = 1'b1;
               end
            end
         end
         S_SQ_ISS: begin
            state_in = S_SQ_WB;
         end
         S_SQ_WB: begin
            sq_in    = mul_res.value;
            clip_in  = clip_ff | mul_res.clip;
            state_in = S_LIN_WB;
         end
         S_LIN_WB: begin
            lin_in   = mul_res.value;
            clip_in  = clip_ff | mul_res.clip;
            state_in = S_CUBE_WB;
         end
         S_CUBE_WB: begin
            cube_in  = mul_res.value;
            clip_in  = clip_ff | mul_res.clip;
            state_in = S_F_CALC;
         end
         S_F_CALC: begin
            f_in     = f_sat.value;
            clip_in  = clip_ff | f_sat.clip;
            state_in = S_K_ISS;
         end
         S_K_ISS: begin
            state_in = S_K_WB;
         end
         S_K_WB: begin
            acc_in = acc_ff + k_term;
            if (stage_ff == STAGE_LAST) begin
               clip_in  = clip_ff | mul_res.clip;
               state_in = S_DIV_ISS;
            end else begin
               t_in     = trial_sat.value;
               clip_in  = clip_ff | mul_res.clip | trial_sat.clip;
               stage_in = stage_ff + 2'd1;
               state_in = S_SQ_ISS;
            end
         end
         S_DIV_ISS: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_INC;
            end
         end
         S_INC: begin
            inc_in   = inc_sat.value;
            clip_in  = clip_ff | inc_sat.clip;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (out_free) begin
               x_in                    = upd_sat.value;
               rsp_item_in.state_value = upd_sat.value;
               rsp_item_in.saturated   = clip_ff | upd_sat.clip;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         x_ff         <= '0;
         coef_a_ff    <= '0;
         coef_b_ff    <= '0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
         stage_ff     <= '0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         coef_a_ff    <= coef_a_in;
         coef_b_ff    <= coef_b_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         stage_ff     <= stage_in;
         clip_ff      <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      sq_ff       <= sq_in;
      lin_ff      <= lin_in;
      cube_ff     <= cube_in;
      f_ff        <= f_in;
      inc_ff      <= inc_in;
      acc_ff      <= acc_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

/* sim/rk4_cubic_ode_step_top_test.sv */
// Self-checking bench for rk4_cubic_ode_step_top: directed rows, then random load/step runs
// across register settings, checked against a Q16.16 RK4 predictor. Depends on rk4_pkg.
`timescale 1ns / 1ps

module rk4_cubic_ode_step_top_test;
   import rk4_pkg::*;

   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     DRAIN_CYCLES  = 60;
   localparam int     PHASE_ITEMS   = 220;
   localparam int     CHUNK_ITEMS   = 55;
   localparam int     DIRECTED_ROWS = 27;
   localparam longint Q16_MAX       = 64'sd2147483647;
   localparam longint Q16_MIN       = -64'sd2147483648;
   localparam longint ROUND_BIT     = 64'sd32768;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic                 command;
      logic [FIX_W-1:0]     data;
      logic                 has_want;
      logic [FIX_W-1:0]     want_value;
      logic                 want_sat;
   } stim_row_type;

   // data is the start value for items and the write data for register rows
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_A, CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_B, CMD_LOAD, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_STEP_H, CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_A, CMD_LOAD, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_B, CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_STEP_H, CMD_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_UNUSED, CMD_LOAD, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_STEP_H, CMD_LOAD, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_LOAD, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, CSR_COEF_A, CMD_STEP, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_A, CMD_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_COEF_B, CMD_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  CSR_STEP_H, CMD_LOAD, 32'h0000_199A, 1'b0, 32'h0000_0000, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_item;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIX_W-1:0]     csr_data;

   int      error_count    = 0;
   int      cycle_count    = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      hold_requests  = 0;
   int      hold_served    = 0;
   rsp_type pending_states[$];

   // predictor state
   longint coef_a_q;
   longint coef_b_q;
   longint step_h_q;
   longint x_q;
   bit     clip_q;

   rk4_cubic_ode_step_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint q16_clamp(input longint v);
      if (v > Q16_MAX) begin
         clip_q = 1'b1;
         return Q16_MAX;
      end
      if (v < Q16_MIN) begin
         clip_q = 1'b1;
         return Q16_MIN;
      end
      return v;
   endfunction

   // round half up at 16 fraction bits; >>> on the signed product is a floor
   function automatic longint q16_mul(input longint p, input longint q);
      return q16_clamp((p * q + ROUND_BIT) >>> FRAC_BITS);
   endfunction

   function automatic longint cubic_slope(input longint x);
      longint sq;
      longint cube;
      longint lin;
      sq   = q16_mul(x, x);
      cube = q16_mul(sq, x);
      lin  = q16_mul(coef_a_q, x);
      return q16_clamp(lin - cube - coef_b_q);
   endfunction

   function automatic void rk4_advance();
      longint k1;
      longint k2;
      longint k3;
      longint k4;
      longint total;
      longint quot;
      k1    = q16_mul(step_h_q, cubic_slope(x_q));
      k2    = q16_mul(step_h_q, cubic_slope(q16_clamp(x_q + (k1 >>> 1))));
      k3    = q16_mul(step_h_q, cubic_slope(q16_clamp(x_q + (k2 >>> 1))));
      k4    = q16_mul(step_h_q, cubic_slope(q16_clamp(x_q + k3)));
      total = k1 + 2 * k2 + 2 * k3 + k4 + 3;
      // divide by six rounding toward minus infinity
      quot  = total / 6;
      if ((total % 6) != 0 && total < 0) quot = quot - 1;
      x_q = q16_clamp(x_q + q16_clamp(quot));
   endfunction

   function automatic rsp_type expected_state(input req_type item);
      rsp_type r;
      clip_q = 1'b0;
      if (item.command == CMD_LOAD) x_q = q16_clamp(longint'($signed(item.start_value)));
      else rk4_advance();
      r.state_value = x_q[FIX_W-1:0];
      r.saturated   = clip_q;
      return r;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [FIX_W-1:0] data);
      case (idx)
         CSR_COEF_A: coef_a_q = longint'($signed(data));
         CSR_COEF_B: coef_b_q = longint'($signed(data));
         CSR_STEP_H: step_h_q = longint'(data[STEP_W-1:0]);
         default:    ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_states.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%h sat=%b",
                                      rsp_item.state_value, rsp_item.saturated));
         end else begin
            want = pending_states.pop_front();
            if (rsp_item.state_value !== want.state_value)
               report_mismatch($sformatf("state_value got %h want %h",
                                         rsp_item.state_value, want.state_value));
            if (rsp_item.saturated !== want.saturated)
               report_mismatch($sformatf("saturated got %b want %b (x=%h)",
                                         rsp_item.saturated, want.saturated,
                                         want.state_value));
         end
      end
   end

   // result side: random stalls, plus long hold-offs on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
            hold_served = hold_requests;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input req_type item, input bit has_want, input rsp_type want);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (has_want) begin
         void'(expected_state(item));
         pending_states.push_back(want);
      end else begin
         pending_states.push_back(expected_state(item));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; send_item lowers it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [FIX_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic new_setting();
      logic [FIX_W-1:0] a;
      logic [FIX_W-1:0] b;
      logic [FIX_W-1:0] h;
      if ($urandom_range(9) < 7) begin
         // a, b within +-4.0, h up to 0.5: trajectories stay mostly in range
         a = $urandom_range(524288) - 262144;
         b = $urandom_range(524288) - 262144;
         h = $urandom_range(32768);
      end else begin
         a = $urandom;
         b = $urandom;
         h = $urandom;
      end
      wait_idle();
      write_csr(CSR_COEF_A, a);
      write_csr(CSR_COEF_B, b);
      write_csr(CSR_STEP_H, h);
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, $urandom);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit pressure);
      int      n;
      req_type item;
      rsp_type none;
      none           = '0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (n % CHUNK_ITEMS == 0) new_setting();
         if (pressure && (n % 110) == 5) hold_requests++;
         // each setting starts from a fresh load, then mostly step runs
         if (n % CHUNK_ITEMS == 0 || $urandom_range(7) == 0) item.command = CMD_LOAD;
         else item.command = CMD_STEP;
         if ($urandom_range(3) == 0) item.start_value = $urandom;
         else item.start_value = $urandom_range(393216) - 196608;
         send_item(item, 1'b0, none);
      end
   endtask

   initial begin
      int      r;
      req_type item;
      rsp_type want;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COEF_A;
      csr_data  = '0;
      coef_a_q  = 0;
      coef_b_q  = 0;
      step_h_q  = longint'(STEP_RESET);
      x_q       = 0;
      clip_q    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[r].index, directed_rows[r].data);
         end else begin
            item.command     = directed_rows[r].command;
            item.start_value = directed_rows[r].data;
            want.state_value = directed_rows[r].want_value;
            want.saturated   = directed_rows[r].want_sat;
            send_item(item, directed_rows[r].has_want, want);
         end
      end

      run_phase(0, 0, 1'b0);
      run_phase(66, 0, 1'b0);
      run_phase(0, 66, 1'b0);
      run_phase(26, 26, 1'b0);
      run_phase(0, 0, 1'b1);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
